[rtl/lctm_pkg.sv]
// ----------------------------------------------------------------------------
// lctm_pkg
// shared types, constants and sizes of the load cell trimmed mean detector
// ----------------------------------------------------------------------------
package lctm_pkg;

    localparam int SAMPLES = 10;
    localparam int TRIM    = 2;
    localparam int KEPT    = SAMPLES - 2 * TRIM;

    localparam int RAW_W   = 24;
    localparam int WGT_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int LCNT_W  = 8;
    localparam int PROD_W  = RAW_W + GAIN_W;

    localparam int CNT_W   = $clog2(SAMPLES);
    localparam int SUM_W   = WGT_W + $clog2(KEPT);
    localparam int RECIP_W = SUM_W + 1;
    localparam int DPROD_W = SUM_W + RECIP_W;

    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((1 << SUM_W) / KEPT);
    localparam logic [RAW_W-1:0]   SIGN_FLIP = RAW_W'(24'h80_0000);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STABLE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd5;

    localparam logic [RAW_W-1:0]  TARE_RST      = '0;
    localparam logic [GAIN_W-1:0] GAIN_RST      = 16'd1638;
    localparam logic [WGT_W-1:0]  STABLE_RST    = 16'd3;
    localparam logic [WGT_W-1:0]  LOW_LIMIT_RST = 16'd100;
    localparam logic [LCNT_W-1:0] LOW_COUNT_RST = 8'd10;
    localparam logic [WGT_W-1:0]  THRESHOLD_RST = 16'd25;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_LOW  = 2'd1,
        EV_INC  = 2'd2,
        EV_DEC  = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB,
        ST_MUL,
        ST_INSERT,
        ST_DRAIN,
        ST_DIV1,
        ST_DIV2,
        ST_JUDGE
    } state_t;

    typedef struct packed {
        logic load;
        logic sub;
        logic mul;
    } weight_ctrl_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctrl_t;

endpackage

[rtl/lctm_weight.sv]
// ----------------------------------------------------------------------------
// lctm_weight
// raw converter word to saturated weight: offset, tare subtract, gain scale
// ----------------------------------------------------------------------------
module lctm_weight (
    input  logic                                 clk,
    input  lctm_pkg::weight_ctrl_t               ctrl,
    input  logic [lctm_pkg::RAW_W-1:0]           raw,
    input  logic [lctm_pkg::RAW_W-1:0]           tare,
    input  logic [lctm_pkg::GAIN_W-1:0]          gain,
    output logic [lctm_pkg::WGT_W-1:0]           weight
);
    import lctm_pkg::*;

    logic [RAW_W-1:0]  raw_reg;
    logic [RAW_W-1:0]  diff_reg;
    logic              pos_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RAW_W-1:0]  offset_val;

    assign offset_val = raw_reg ^ SIGN_FLIP;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            raw_reg <= raw;
        end
        if (ctrl.sub)
        begin
            diff_reg <= offset_val - tare;
            pos_reg  <= offset_val > tare;
        end
        if (ctrl.mul)
        begin
            prod_reg <= pos_reg ? PROD_W'(diff_reg) * PROD_W'(gain) : '0;
        end
    end

    // saturate the 24.16 result to the weight range
    assign weight = (|prod_reg[PROD_W-1:WGT_W+16]) ? '1 : prod_reg[WGT_W+15:16];

endmodule

[rtl/lctm_cell.sv]
// ----------------------------------------------------------------------------
// lctm_cell
// one slot of the insertion sorting chain, holds one weight of the batch
// ----------------------------------------------------------------------------
module lctm_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lctm_pkg::chain_ctrl_t         ctrl,
    input  logic [lctm_pkg::WGT_W-1:0]    x,
    input  logic [lctm_pkg::WGT_W-1:0]    left_val,
    input  logic                          left_valid,
    input  logic                          left_greater,
    output logic [lctm_pkg::WGT_W-1:0]    val,
    output logic                          valid,
    output logic                          greater
);
    import lctm_pkg::*;

    logic [WGT_W-1:0] val_reg;
    logic [WGT_W-1:0] val_next;
    logic             valid_reg;
    logic             valid_next;

    assign greater = valid_reg && (val_reg > x);
    assign val     = val_reg;
    assign valid   = valid_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        priority if (ctrl.shift)
        begin
            val_next   = left_val;
            valid_next = left_valid;
        end
        else if (ctrl.insert && (!valid_reg || greater))
        begin
            priority if (left_greater)
            begin
                val_next   = left_val;
                valid_next = 1'b1;
            end
            else if (left_valid)
            begin
                val_next   = x;
                valid_next = 1'b1;
            end
            else
            begin
                val_next   = val_reg;
            end
        end
        else
        begin
            val_next   = val_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

[rtl/lctm_chain.sv]
// ----------------------------------------------------------------------------
// lctm_chain
// row of sorting cells; drains through the far end and sums the kept middle
// ----------------------------------------------------------------------------
module lctm_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lctm_pkg::chain_ctrl_t         ctrl,
    input  logic [lctm_pkg::WGT_W-1:0]    x,
    output logic [lctm_pkg::SUM_W-1:0]    sum,
    output logic                          drain_last
);
    import lctm_pkg::*;

    logic [WGT_W-1:0] cell_val   [SAMPLES];
    logic             cell_valid [SAMPLES];
    logic             cell_gt    [SAMPLES];

    logic [CNT_W-1:0] drain_cnt_reg;
    logic [CNT_W-1:0] drain_cnt_next;
    logic [SUM_W-1:0] acc_reg;
    logic [SUM_W-1:0] acc_next;
    logic             in_middle;

    genvar gi;
    generate
        for (gi = 0; gi < SAMPLES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                lctm_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (ctrl),
                    .x            (x),
                    .left_val     ('0),
                    .left_valid   (!ctrl.shift),
                    .left_greater (1'b0),
                    .val          (cell_val[gi]),
                    .valid        (cell_valid[gi]),
                    .greater      (cell_gt[gi])
                );
            end
            else
            begin : g_body
                lctm_cell u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (ctrl),
                    .x            (x),
                    .left_val     (cell_val[gi-1]),
                    .left_valid   (cell_valid[gi-1]),
                    .left_greater (cell_gt[gi-1]),
                    .val          (cell_val[gi]),
                    .valid        (cell_valid[gi]),
                    .greater      (cell_gt[gi])
                );
            end
        end
    endgenerate

    // the far cell shows the largest first, so the kept window is symmetric
    assign in_middle  = (drain_cnt_reg >= CNT_W'(TRIM)) &&
                        (drain_cnt_reg < CNT_W'(SAMPLES - TRIM));
    assign drain_last = ctrl.shift && (drain_cnt_reg == CNT_W'(SAMPLES - 1));
    assign sum        = acc_reg;

    always_comb
    begin
        drain_cnt_next = drain_cnt_reg;
        acc_next       = acc_reg;
        if (ctrl.shift)
        begin
            drain_cnt_next = drain_last ? '0 : drain_cnt_reg + 1'b1;
            acc_next       = ((drain_cnt_reg == '0) ? '0 : acc_reg) +
                             (in_middle ? SUM_W'(cell_val[SAMPLES-1]) : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_cnt_reg <= '0;
        end
        else
        begin
            drain_cnt_reg <= drain_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

endmodule

[rtl/load_cell_trimmed_mean_change_detector.sv]
// ----------------------------------------------------------------------------
// load_cell_trimmed_mean_change_detector
// weight conversion, sorting chain trimmed mean and settle / change judgement
// ----------------------------------------------------------------------------
// an item is taken in idle; subtract, multiply, insert into the chain follow
// before the next is taken; the last item of a batch adds chain drain, two
// divide steps by reciprocal, judgement; the result register loads after that
// the result register parts the output side; a stalled result holds off
// the judgement of the next batch and with it the intake of further items
// reset clears control, counters, settle history and the config registers to defaults
module load_cell_trimmed_mean_change_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [lctm_pkg::RAW_W-1:0]         raw_sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         event_res,
    output logic [lctm_pkg::WGT_W-1:0]         change_amount,
    output logic [lctm_pkg::WGT_W-1:0]         average_weight,
    output logic                               settled,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lctm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lctm_pkg::RAW_W-1:0]         cfg_data
);
    import lctm_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [RAW_W-1:0]  tare_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [WGT_W-1:0]  stable_reg;
    logic [WGT_W-1:0]  low_limit_reg;
    logic [LCNT_W-1:0] low_report_reg;
    logic [WGT_W-1:0]  threshold_reg;

    logic [CNT_W-1:0]  batch_cnt_reg;
    logic [CNT_W-1:0]  batch_cnt_next;
    logic [WGT_W-1:0]  last_reading_reg;
    logic [WGT_W-1:0]  last_reading_next;
    logic [WGT_W-1:0]  last_settled_reg;
    logic [WGT_W-1:0]  last_settled_next;
    logic [LCNT_W-1:0] low_count_reg;
    logic [LCNT_W-1:0] low_count_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    event_t            event_reg;
    event_t            event_next;
    logic [WGT_W-1:0]  change_reg;
    logic [WGT_W-1:0]  change_next;
    logic [WGT_W-1:0]  avg_out_reg;
    logic              settled_reg;
    logic              settled_next;

    weight_ctrl_t      wctrl;
    chain_ctrl_t       cctrl;
    logic              div1_en;
    logic              div2_en;
    logic              judge_en;
    logic              out_free;
    logic              batch_end;

    logic [WGT_W-1:0]   weight;
    logic [SUM_W-1:0]   sum;
    logic               drain_last;
    logic [DPROD_W-1:0] recip_prod;
    logic [SUM_W-1:0]   q0_reg;
    logic [SUM_W-1:0]   rem;
    logic [WGT_W-1:0]   avg_reg;

    logic [WGT_W:0]     avg_ext;
    logic [WGT_W:0]     reading_ext;
    logic [WGT_W:0]     settled_ext;
    logic               unsettled;

    lctm_weight u_weight (
        .clk    (clk),
        .ctrl   (wctrl),
        .raw    (raw_sample),
        .tare   (tare_reg),
        .gain   (gain_reg),
        .weight (weight)
    );

    lctm_chain u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (cctrl),
        .x          (weight),
        .sum        (sum),
        .drain_last (drain_last)
    );

    assign cfg_ready      = 1'b1;
    assign out_valid      = out_valid_reg;
    assign event_res      = event_reg;
    assign change_amount  = change_reg;
    assign average_weight = avg_out_reg;
    assign settled        = settled_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign batch_end = batch_cnt_reg == CNT_W'(SAMPLES - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   state_next = in_valid ? ST_SUB : ST_IDLE;
            ST_SUB:    state_next = ST_MUL;
            ST_MUL:    state_next = ST_INSERT;
            ST_INSERT: state_next = batch_end ? ST_DRAIN : ST_IDLE;
            ST_DRAIN:  state_next = drain_last ? ST_DIV1 : ST_DRAIN;
            ST_DIV1:   state_next = ST_DIV2;
            ST_DIV2:   state_next = ST_JUDGE;
            ST_JUDGE:  state_next = out_free ? ST_IDLE : ST_JUDGE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall     = 1'b1;
        wctrl        = '0;
        cctrl        = '0;
        div1_en      = 1'b0;
        div2_en      = 1'b0;
        judge_en     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                wctrl.load = in_valid;
            end
            ST_SUB:    wctrl.sub    = 1'b1;
            ST_MUL:    wctrl.mul    = 1'b1;
            ST_INSERT: cctrl.insert = 1'b1;
            ST_DRAIN:  cctrl.shift  = 1'b1;
            ST_DIV1:   div1_en      = 1'b1;
            ST_DIV2:   div2_en      = 1'b1;
            ST_JUDGE:  judge_en     = out_free;
            default:   in_stall     = 1'b1;
        endcase
    end

    assign batch_cnt_next = cctrl.insert ? (batch_end ? '0 : batch_cnt_reg + 1'b1)
                                         : batch_cnt_reg;

    // divide by the kept count: reciprocal estimate, then one correction
    assign recip_prod = DPROD_W'(sum) * DPROD_W'(DIV_RECIP);
    assign rem        = sum - SUM_W'(q0_reg * SUM_W'(KEPT));

    always_ff @(posedge clk)
    begin
        if (div1_en)
        begin
            q0_reg <= SUM_W'(recip_prod[DPROD_W-1:SUM_W]);
        end
        if (div2_en)
        begin
            avg_reg <= (rem >= SUM_W'(KEPT)) ? WGT_W'(q0_reg + 1'b1) : WGT_W'(q0_reg);
        end
    end

    assign avg_ext     = {1'b0, avg_reg};
    assign reading_ext = {1'b0, last_reading_reg};
    assign settled_ext = {1'b0, last_settled_reg};
    assign unsettled   = (avg_ext > reading_ext + {1'b0, stable_reg}) ||
                         (reading_ext > avg_ext + {1'b0, stable_reg});

    always_comb
    begin
        last_reading_next = last_reading_reg;
        last_settled_next = last_settled_reg;
        low_count_next    = low_count_reg;
        event_next        = event_reg;
        change_next       = change_reg;
        settled_next      = settled_reg;
        out_valid_next    = out_valid_reg && out_stall;
        if (judge_en)
        begin
            out_valid_next    = 1'b1;
            event_next        = EV_NONE;
            change_next       = '0;
            last_reading_next = avg_reg;
            priority if (unsettled)
            begin
                settled_next = 1'b0;
            end
            else if (avg_reg < low_limit_reg)
            begin
                settled_next      = 1'b1;
                last_settled_next = avg_reg;
                if (low_count_reg < low_report_reg)
                begin
                    event_next     = EV_LOW;
                    low_count_next = low_count_reg + 1'b1;
                end
            end
            else if (avg_reg >= last_settled_reg)
            begin
                settled_next      = 1'b1;
                last_settled_next = avg_reg;
                low_count_next    = '0;
                if (avg_ext >= settled_ext + {1'b0, threshold_reg})
                begin
                    event_next  = (last_settled_reg == '0) ? EV_NONE : EV_INC;
                    change_next = avg_reg - last_settled_reg;
                end
            end
            else
            begin
                settled_next      = 1'b1;
                last_settled_next = avg_reg;
                low_count_next    = '0;
                if (settled_ext >= avg_ext + {1'b0, threshold_reg})
                begin
                    event_next  = EV_DEC;
                    change_next = last_settled_reg - avg_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            batch_cnt_reg    <= '0;
            last_reading_reg <= '0;
            last_settled_reg <= '0;
            low_count_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            batch_cnt_reg    <= batch_cnt_next;
            last_reading_reg <= last_reading_next;
            last_settled_reg <= last_settled_next;
            low_count_reg    <= low_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg   <= event_next;
        change_reg  <= change_next;
        settled_reg <= settled_next;
        if (judge_en)
        begin
            avg_out_reg <= avg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg       <= TARE_RST;
            gain_reg       <= GAIN_RST;
            stable_reg     <= STABLE_RST;
            low_limit_reg  <= LOW_LIMIT_RST;
            low_report_reg <= LOW_COUNT_RST;
            threshold_reg  <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARE:      tare_reg       <= cfg_data;
                CFG_GAIN:      gain_reg       <= cfg_data[GAIN_W-1:0];
                CFG_STABLE:    stable_reg     <= cfg_data[WGT_W-1:0];
                CFG_LOW_LIMIT: low_limit_reg  <= cfg_data[WGT_W-1:0];
                CFG_LOW_COUNT: low_report_reg <= cfg_data[LCNT_W-1:0];
                CFG_THRESHOLD: threshold_reg  <= cfg_data[WGT_W-1:0];
                default:       tare_reg       <= tare_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_result_from_judge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_JUDGE))
        else $error("result appeared outside judgement");

    a_transfer_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SUB))
        else $error("input transfer did not start conversion");

    a_unsettled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !settled_reg) |-> (event_reg == EV_NONE && change_reg == '0))
        else $error("unsettled result carries an event");

    a_low_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == EV_LOW) |-> (change_reg == '0))
        else $error("low weight result carries a change");
`endif

endmodule
